@@ sv/fdem_pkg.sv @@
`default_nettype none

package fdem_pkg;

  localparam int unsigned APB_ADDR_W = 6;
  localparam int unsigned APB_DATA_W = 64;

  typedef enum logic [2:0] {
    REG_NAME_HEAD   = 3'd0,
    REG_NAME_TAIL   = 3'd1,
    REG_FAT32_MODE  = 3'd2,
    REG_DATA_START  = 3'd3,
    REG_CLUS_SECS   = 3'd4
  } reg_idx_e;

  localparam logic [7:0] DEL_MARK  = 8'hE5;
  localparam logic [7:0] END_MARK  = 8'h00;
  localparam logic [7:0] ATTR_SKIP = 8'h18;

  localparam logic [4:0] OFF_FIRST     = 5'd0;
  localparam logic [4:0] OFF_NAME_LAST = 5'd10;
  localparam logic [4:0] OFF_ATTR      = 5'd11;
  localparam logic [4:0] OFF_CLUS_HI0  = 5'd20;
  localparam logic [4:0] OFF_CLUS_HI1  = 5'd21;
  localparam logic [4:0] OFF_CLUS_LO0  = 5'd26;
  localparam logic [4:0] OFF_CLUS_LO1  = 5'd27;
  localparam logic [4:0] OFF_SIZE0     = 5'd28;
  localparam logic [4:0] OFF_SIZE1     = 5'd29;
  localparam logic [4:0] OFF_SIZE2     = 5'd30;
  localparam logic [4:0] OFF_LAST      = 5'd31;

  localparam logic [31:0] CLUS_BASE = 32'd2;

  typedef struct packed {
    logic [63:0] name_head;
    logic [23:0] name_tail;
    logic        fat32_mode;
    logic [31:0] data_region_start;
    logic [7:0]  cluster_sectors;
  } cfg_t;

  typedef struct packed {
    logic        valid;
    logic        hit;
    logic [31:0] cluster;
    logic [31:0] size;
    logic [31:0] prod;
  } entry_done_t;

endpackage

`default_nettype wire

@@ sv/fdem_req_if.sv @@
`default_nettype none

interface fdem_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] dir_byte;
  logic       restart;

  modport source (output valid, output dir_byte, output restart, input ready);
  modport sink (input valid, input dir_byte, input restart, output ready);
endinterface

`default_nettype wire

@@ sv/fdem_rsp_if.sv @@
`default_nettype none

interface fdem_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [31:0] start_cluster;
  logic [31:0] file_bytes;
  logic [31:0] start_sector;

  modport source (output valid, output hit, output start_cluster, output file_bytes,
                  output start_sector, input ready);
  modport sink (input valid, input hit, input start_cluster, input file_bytes,
                input start_sector, output ready);
endinterface

`default_nettype wire

@@ sv/fdem_apb_regs.sv @@
`default_nettype none

module fdem_apb_regs
  import fdem_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready,
  output cfg_t                       cfg_o
);

  cfg_t     cfg_q, cfg_d;
  reg_idx_e idx;
  logic     wr_en;

  assign idx    = reg_idx_e'(paddr[APB_ADDR_W-1:3]);
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;
  assign cfg_o  = cfg_q;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        REG_NAME_HEAD:  cfg_d.name_head         = pwdata[63:0];
        REG_NAME_TAIL:  cfg_d.name_tail         = pwdata[23:0];
        REG_FAT32_MODE: cfg_d.fat32_mode        = pwdata[0];
        REG_DATA_START: cfg_d.data_region_start = pwdata[31:0];
        REG_CLUS_SECS:  cfg_d.cluster_sectors   = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_NAME_HEAD:  prdata = cfg_q.name_head;
      REG_NAME_TAIL:  prdata = {40'd0, cfg_q.name_tail};
      REG_FAT32_MODE: prdata = {63'd0, cfg_q.fat32_mode};
      REG_DATA_START: prdata = {32'd0, cfg_q.data_region_start};
      REG_CLUS_SECS:  prdata = {56'd0, cfg_q.cluster_sectors};
      default:        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{name_head: '0, name_tail: '0, fat32_mode: 1'b0,
                 data_region_start: '0, cluster_sectors: 8'd1};
    end else begin
      cfg_q <= cfg_d;
    end
  end

endmodule

`default_nettype wire

@@ sv/fdem_entry_parse.sv @@
`default_nettype none

module fdem_entry_parse
  import fdem_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        accept_i,
  input  wire logic [7:0]  dir_byte_i,
  input  wire logic        restart_i,
  input  wire cfg_t        cfg_i,
  output entry_done_t      done_o
);

  logic [4:0]       offset_q, offset_d;
  logic             name_equal_q, name_equal_d;
  logic             usable_q, usable_d;
  logic [31:0]      cluster_q, cluster_d;
  logic [23:0]      size_q, size_d;
  logic [31:0]      prod_q, prod_d;
  logic [4:0]       off;
  logic [10:0][7:0] name_bytes;
  logic [31:0]      cl_sel;

  assign name_bytes = {cfg_i.name_tail, cfg_i.name_head};
  assign off        = restart_i ? OFF_FIRST : offset_q;
  assign cl_sel     = cfg_i.fat32_mode ? cluster_q : {16'd0, cluster_q[15:0]};

  always_comb begin
    offset_d     = offset_q;
    name_equal_d = name_equal_q;
    usable_d     = usable_q;
    cluster_d    = cluster_q;
    size_d       = size_q;
    prod_d       = prod_q;
    if (accept_i) begin
      offset_d = off + 5'd1;
      if (off == OFF_FIRST) begin
        name_equal_d = (dir_byte_i == name_bytes[4'd0]);
        usable_d     = (dir_byte_i != DEL_MARK) && (dir_byte_i != END_MARK);
      end else if (off <= OFF_NAME_LAST) begin
        if (dir_byte_i != name_bytes[off[3:0]]) begin
          name_equal_d = 1'b0;
        end
      end else if (off == OFF_ATTR) begin
        if ((dir_byte_i & ATTR_SKIP) != 8'd0) begin
          usable_d = 1'b0;
        end
      end
      unique case (off)
        OFF_CLUS_HI0: cluster_d[23:16] = dir_byte_i;
        OFF_CLUS_HI1: cluster_d[31:24] = dir_byte_i;
        OFF_CLUS_LO0: cluster_d[7:0]   = dir_byte_i;
        OFF_CLUS_LO1: cluster_d[15:8]  = dir_byte_i;
        OFF_SIZE0: begin
          size_d[7:0] = dir_byte_i;
          prod_d      = 32'((cl_sel - CLUS_BASE) * {24'd0, cfg_i.cluster_sectors});
        end
        OFF_SIZE1:    size_d[15:8]     = dir_byte_i;
        OFF_SIZE2:    size_d[23:16]    = dir_byte_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_q     <= OFF_FIRST;
      name_equal_q <= 1'b1;
      usable_q     <= 1'b1;
    end else begin
      offset_q     <= offset_d;
      name_equal_q <= name_equal_d;
      usable_q     <= usable_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cluster_q <= cluster_d;
    size_q    <= size_d;
    prod_q    <= prod_d;
  end

  assign done_o.valid   = accept_i && (off == OFF_LAST);
  assign done_o.hit     = name_equal_q && usable_q;
  assign done_o.cluster = cl_sel;
  assign done_o.size    = {dir_byte_i, size_q};
  assign done_o.prod    = prod_q;

endmodule

`default_nettype wire

@@ sv/fdem_result.sv @@
`default_nettype none

module fdem_result
  import fdem_pkg::*;
(
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire entry_done_t done_i,
  input  wire logic [31:0] data_region_start_i,
  output logic             take_ready_o,
  fdem_rsp_if.source       rsp_o
);

  logic        valid_q, valid_d;
  logic        hit_q;
  logic [31:0] cluster_q;
  logic [31:0] size_q;
  logic [31:0] sector_q;

  assign take_ready_o = !(valid_q && !rsp_o.ready);

  always_comb begin
    valid_d = valid_q;
    if (done_i.valid) begin
      valid_d = 1'b1;
    end else if (rsp_o.ready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_i.valid) begin
      hit_q     <= done_i.hit;
      cluster_q <= done_i.cluster;
      size_q    <= done_i.size;
      sector_q  <= data_region_start_i + done_i.prod;
    end
  end

  assign rsp_o.valid         = valid_q;
  assign rsp_o.hit           = hit_q;
  assign rsp_o.start_cluster = cluster_q;
  assign rsp_o.file_bytes    = size_q;
  assign rsp_o.start_sector  = sector_q;

endmodule

`default_nettype wire

@@ sv/fat_directory_entry_matcher.sv @@
// fat directory entry matcher
// req_i carries one directory byte per request (dir_byte, restart); restart marks
// the byte as offset 0 of a fresh entry and drops any partial entry
// every 32nd byte (entry offset 31) produces one response on rsp_o with hit,
// start cluster, file size and first data sector of that entry
// throughput: one request per cycle, sustained while no response stalls, since the
// entry parser updates its state for each byte in the cycle the byte is taken
// latency: the response is valid in the cycle after its last byte is taken
// the cluster-to-sector product is registered at offset 28, the final add runs
// into the response register
// a 64-bit apb port holds the name, mode, data start and cluster size at 8*index
// configuration is to be written only while no entry is in progress; the block does not check it
// reset clears the entry offset to 0, drops a pending response and sets
// sectors per cluster to 1, the other configuration registers to 0
// when the receiver stalls, the response holds and req_i.ready drops until it
// is taken; a waiting response never blocks a new request in the cycle it is taken
`default_nettype none

module fat_directory_entry_matcher
  import fdem_pkg::*;
(
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  fdem_req_if.sink                   req_i,
  fdem_rsp_if.source                 rsp_o,
  input  wire logic                  psel,
  input  wire logic                  penable,
  input  wire logic                  pwrite,
  input  wire logic [APB_ADDR_W-1:0] paddr,
  input  wire logic [APB_DATA_W-1:0] pwdata,
  output logic      [APB_DATA_W-1:0] prdata,
  output logic                       pready
);

  cfg_t        cfg;
  entry_done_t done;
  logic        take_ready;
  logic        accept;

  assign req_i.ready = take_ready;
  assign accept      = req_i.valid && take_ready;

  fdem_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  fdem_entry_parse u_parse (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .accept_i   (accept),
    .dir_byte_i (req_i.dir_byte),
    .restart_i  (req_i.restart),
    .cfg_i      (cfg),
    .done_o     (done)
  );

  fdem_result u_result (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .done_i              (done),
    .data_region_start_i (cfg.data_region_start),
    .take_ready_o        (take_ready),
    .rsp_o               (rsp_o)
  );

endmodule

`default_nettype wire

@@ sv/fdem_checker.sv @@
`default_nettype none

module fdem_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid,
  input wire logic        in_ready,
  input wire logic        in_restart,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_hit,
  input wire logic [31:0] out_sector,
  input wire logic        pready
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_hit) && $stable(out_sector))
    else $error("response changed while stalled");

  a_stall_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |-> !in_ready)
    else $error("request taken while response stalled");

  a_rsp_after_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid) |-> $past(in_valid && in_ready))
    else $error("response without a request");

  a_restart_no_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid && in_ready && in_restart && !out_valid |=> !out_valid)
    else $error("response after restart byte");

  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pready)
    else $error("apb wait state");

endmodule

bind fat_directory_entry_matcher fdem_checker u_fdem_checker (
  .clk_i      (clk_i),
  .rst_ni     (rst_ni),
  .in_valid   (req_i.valid),
  .in_ready   (req_i.ready),
  .in_restart (req_i.restart),
  .out_valid  (rsp_o.valid),
  .out_ready  (rsp_o.ready),
  .out_hit    (rsp_o.hit),
  .out_sector (rsp_o.start_sector),
  .pready     (pready)
);

`default_nettype wire

@@ sim/tb_fat_directory_entry_matcher.sv @@
`default_nettype none

module tb_fat_directory_entry_matcher
  import fdem_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned IDLE_LIMIT = 2000;
  localparam int unsigned ENTRY_BYTES = 32;
  localparam int unsigned NAME_BYTES = 11;

  typedef struct packed {
    logic        hit;
    logic [31:0] start_cluster;
    logic [31:0] file_bytes;
    logic [31:0] start_sector;
  } dir_result_t;

  typedef struct packed {
    logic [1:0]  cfg_set;
    logic        rs;
    logic        named;
    logic        rnd_fill;
    logic [7:0]  fill;
    logic        own_first;
    logic [7:0]  first_byte;
    logic        flip_en;
    logic [3:0]  flip;
    logic [7:0]  attr;
    logic [15:0] clus_hi;
    logic [15:0] clus_lo;
    logic [31:0] file_len;
    logic [4:0]  cut;
    logic        typed;
    dir_result_t want;
  } dir_row_t;

  logic clk_i = 1'b0;
  logic rst_ni;

  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [APB_ADDR_W-1:0] paddr;
  logic [APB_DATA_W-1:0] pwdata;
  logic [APB_DATA_W-1:0] prdata;
  logic                  pready;

  fdem_req_if req ();
  fdem_rsp_if rsp ();

  fat_directory_entry_matcher dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req_i   (req),
    .rsp_o   (rsp),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  always #5 clk_i = ~clk_i;

  // register shadow and entry parser state
  cfg_t        vol_cfg = '{name_head: '0, name_tail: '0, fat32_mode: 1'b0,
                           data_region_start: '0, cluster_sectors: 8'd1};
  logic [4:0]  cur_offset = '0;
  logic        name_same = 1'b1;
  logic        slot_live = 1'b1;
  logic [31:0] cluster_bytes = '0;
  logic [31:0] length_bytes = '0;

  dir_result_t pending_entries[$];
  dir_result_t got_entry;
  int unsigned mismatch_count = 0;
  int unsigned rsp_hold = 0;
  int unsigned idle_cycles = 0;
  bit          rush = 1'b0;

  logic [63:0] reg_plan [4][5];
  dir_row_t    directed_rows [17];

  function automatic logic [7:0] wanted_name_byte(input int idx);
    if (idx < 8) begin
      return vol_cfg.name_head[8*idx +: 8];
    end
    return vol_cfg.name_tail[8*(idx-8) +: 8];
  endfunction

  function automatic bit parse_dir_byte(input logic [7:0] b, input logic rs,
                                        output dir_result_t res);
    logic [31:0] cl;
    bit          done;
    if (rs) begin
      cur_offset = OFF_FIRST;
    end
    if (cur_offset == OFF_FIRST) begin
      name_same = (b == wanted_name_byte(0));
      slot_live = (b != DEL_MARK) && (b != END_MARK);
      cluster_bytes = '0;
      length_bytes = '0;
    end else if (cur_offset <= OFF_NAME_LAST) begin
      if (b != wanted_name_byte(int'(cur_offset))) begin
        name_same = 1'b0;
      end
    end else if (cur_offset == OFF_ATTR) begin
      if ((b & ATTR_SKIP) != 8'h00) begin
        slot_live = 1'b0;
      end
    end else if (cur_offset == OFF_CLUS_HI0) begin
      cluster_bytes[23:16] = b;
    end else if (cur_offset == OFF_CLUS_HI1) begin
      cluster_bytes[31:24] = b;
    end else if (cur_offset == OFF_CLUS_LO0) begin
      cluster_bytes[7:0] = b;
    end else if (cur_offset == OFF_CLUS_LO1) begin
      cluster_bytes[15:8] = b;
    end else if (cur_offset >= OFF_SIZE0) begin
      length_bytes[8*(cur_offset-OFF_SIZE0) +: 8] = b;
    end
    done = (cur_offset == OFF_LAST);
    res = '0;
    if (done) begin
      cl = vol_cfg.fat32_mode ? cluster_bytes : {16'h0000, cluster_bytes[15:0]};
      res.hit = name_same && slot_live;
      res.start_cluster = cl;
      res.file_bytes = length_bytes;
      res.start_sector = vol_cfg.data_region_start
                         + (cl - CLUS_BASE) * {24'h0, vol_cfg.cluster_sectors};
    end
    cur_offset = cur_offset + 5'd1;
    return done;
  endfunction

  function automatic int unsigned pick_wait();
    return ($urandom_range(0, 2) == 0) ? $urandom_range(0, 12) : 0;
  endfunction

  task automatic flag_mismatch(input string msg);
    $display("mismatch at %0t: %s", $time, msg);
    mismatch_count++;
  endtask

  task automatic check_field(input string field, input logic [31:0] got,
                             input logic [31:0] want);
    if (got !== want) begin
      flag_mismatch($sformatf("%s got %h want %h", field, got, want));
    end
  endtask

  // response side: random stall per response, counted only while one waits
  always @(posedge clk_i) begin
    if (rsp.valid === 1'b1 && rsp.ready) begin
      if (pending_entries.size() == 0) begin
        flag_mismatch("response with no request entry outstanding");
      end else begin
        got_entry = pending_entries.pop_front();
        check_field("hit", {31'h0, rsp.hit}, {31'h0, got_entry.hit});
        check_field("start_cluster", rsp.start_cluster, got_entry.start_cluster);
        check_field("file_bytes", rsp.file_bytes, got_entry.file_bytes);
        check_field("start_sector", rsp.start_sector, got_entry.start_sector);
      end
      rsp_hold = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 12) : 0;
    end else if (rsp.valid === 1'b1 && rsp_hold != 0) begin
      rsp_hold--;
    end
    rsp.ready <= (rsp_hold == 0);
  end

  always @(posedge clk_i) begin
    if ((req.valid && req.ready === 1'b1) || (rsp.valid === 1'b1 && rsp.ready)
        || (psel && penable)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic rs);
    int unsigned gap;
    dir_result_t res;
    gap = rush ? 0 : pick_wait();
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.dir_byte <= b;
    req.restart <= rs;
    do @(posedge clk_i); while (req.ready !== 1'b1);
    if (parse_dir_byte(b, rs, res)) begin
      pending_entries.push_back(res);
    end
  endtask

  task automatic send_entry(input dir_row_t r);
    logic [7:0] ent [ENTRY_BYTES];
    int i;
    rush = ($urandom_range(0, 3) == 0);
    for (i = 0; i < ENTRY_BYTES; i++) begin
      ent[i] = r.rnd_fill ? 8'($urandom) : r.fill;
    end
    if (r.named) begin
      for (i = 0; i < NAME_BYTES; i++) begin
        ent[i] = wanted_name_byte(i);
      end
    end
    if (r.own_first) begin
      ent[OFF_FIRST] = r.first_byte;
    end
    if (r.flip_en) begin
      ent[r.flip] = ent[r.flip] ^ 8'h01;
    end
    ent[OFF_ATTR] = r.attr;
    ent[OFF_CLUS_HI0] = r.clus_hi[7:0];
    ent[OFF_CLUS_HI1] = r.clus_hi[15:8];
    ent[OFF_CLUS_LO0] = r.clus_lo[7:0];
    ent[OFF_CLUS_LO1] = r.clus_lo[15:8];
    for (i = 0; i < 4; i++) begin
      ent[OFF_SIZE0 + i] = r.file_len[8*i +: 8];
    end
    // partial entry, dropped by the restart that follows
    for (i = 0; i < r.cut; i++) begin
      send_byte(r.rnd_fill ? 8'($urandom) : r.fill, i == 0);
    end
    for (i = 0; i < ENTRY_BYTES; i++) begin
      send_byte(ent[i], (i == 0) && (r.rs || r.cut != 0));
    end
    if (r.typed) begin
      pending_entries[$] = r.want;
    end
    rush = 1'b0;
  endtask

  // finish any open entry, then wait until every response is back
  task automatic settle_block();
    while (cur_offset != OFF_FIRST) begin
      send_byte(8'($urandom), 1'b0);
    end
    req.valid <= 1'b0;
    while (pending_entries.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [63:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= APB_ADDR_W'({idx, 3'b000});
    pwdata <= val;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (pready !== 1'b1);
    case (idx)
      REG_NAME_HEAD:  vol_cfg.name_head = val;
      REG_NAME_TAIL:  vol_cfg.name_tail = val[23:0];
      REG_FAT32_MODE: vol_cfg.fat32_mode = val[0];
      REG_DATA_START: vol_cfg.data_region_start = val[31:0];
      REG_CLUS_SECS:  vol_cfg.cluster_sectors = val[7:0];
      default: ;
    endcase
  endtask

  task automatic load_regs(input int s);
    reg_idx_e r;
    r = r.first();
    repeat (r.num()) begin
      write_reg(r, reg_plan[s][r]);
      r = r.next();
    end
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic plan_random_regs(input int s);
    reg_plan[s][REG_NAME_HEAD] = {$urandom, $urandom};
    if ($urandom_range(0, 7) == 0) begin
      reg_plan[s][REG_NAME_HEAD][7:0] = ($urandom_range(0, 1) == 0) ? DEL_MARK : END_MARK;
    end
    reg_plan[s][REG_NAME_TAIL] = {$urandom, $urandom};
    reg_plan[s][REG_FAT32_MODE] = ($urandom_range(0, 1) == 0) ? 64'(1) : {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0:       reg_plan[s][REG_DATA_START] = '0;
      1:       reg_plan[s][REG_DATA_START] = '1;
      default: reg_plan[s][REG_DATA_START] = {$urandom, $urandom};
    endcase
    case ($urandom_range(0, 5))
      0:       reg_plan[s][REG_CLUS_SECS] = 64'(0);
      1:       reg_plan[s][REG_CLUS_SECS] = 64'(1);
      2:       reg_plan[s][REG_CLUS_SECS] = 64'(128);
      3:       reg_plan[s][REG_CLUS_SECS] = {$urandom, $urandom};
      default: reg_plan[s][REG_CLUS_SECS] = 64'($urandom_range(1, 128));
    endcase
  endtask

  function automatic dir_row_t random_row();
    dir_row_t r;
    r = '0;
    r.named = 1'b1;
    r.rs = ($urandom_range(0, 3) != 0);
    r.rnd_fill = 1'b1;
    r.attr = 8'($urandom) & ~ATTR_SKIP;
    r.clus_hi = 16'($urandom);
    r.clus_lo = 16'($urandom);
    r.file_len = $urandom;
    case ($urandom_range(0, 11))
      0: begin
        r.flip_en = 1'b1;
        r.flip = 4'($urandom_range(0, NAME_BYTES - 1));
      end
      1: begin
        r.own_first = 1'b1;
        r.first_byte = ($urandom_range(0, 1) == 0) ? DEL_MARK : END_MARK;
      end
      2: r.attr = 8'($urandom);
      3: r.cut = 5'($urandom_range(1, ENTRY_BYTES - 1));
      4: begin
        r.clus_hi = '0;
        r.clus_lo = 16'($urandom_range(0, 3));
      end
      5: begin
        r.clus_hi = '1;
        r.clus_lo = '1;
        r.file_len = '1;
      end
      6: r.named = 1'b0;
      default: ;
    endcase
    return r;
  endfunction

  initial begin
    int cur_set;
    int p;
    int k;
    int n;
    rst_ni = 1'b0;
    req.valid = 1'b0;
    req.dir_byte = '0;
    req.restart = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;

    // "README  TXT", fat32, data at 0x1000, 8 sectors per cluster
    reg_plan[1][REG_NAME_HEAD] = 64'h2020_454D_4441_4552;
    reg_plan[1][REG_NAME_TAIL] = 64'h0000_0000_0054_5854;
    reg_plan[1][REG_FAT32_MODE] = 64'h1;
    reg_plan[1][REG_DATA_START] = 64'h0000_0000_0000_1000;
    reg_plan[1][REG_CLUS_SECS] = 64'h8;
    // all ones, upper bits dropped, zero sectors per cluster
    reg_plan[2][REG_NAME_HEAD] = '1;
    reg_plan[2][REG_NAME_TAIL] = '1;
    reg_plan[2][REG_FAT32_MODE] = '1;
    reg_plan[2][REG_DATA_START] = '1;
    reg_plan[2][REG_CLUS_SECS] = 64'hFFFF_FFFF_FFFF_FF00;

    directed_rows = '{
      // reset values: end mark entry, then all ones through offset wrap
      '{cfg_set: 2'd0, rs: 1'b1, typed: 1'b1,
        want: '{1'b0, 32'h0, 32'h0, 32'hFFFF_FFFE}, default: '0},
      '{cfg_set: 2'd0, fill: 8'hFF, attr: 8'hFF, clus_hi: 16'hFFFF, clus_lo: 16'hFFFF,
        file_len: 32'hFFFF_FFFF, typed: 1'b1,
        want: '{1'b0, 32'h0000_FFFF, 32'hFFFF_FFFF, 32'h0000_FFFD}, default: '0},
      '{cfg_set: 2'd1, rs: 1'b1, named: 1'b1, fill: 8'h20, attr: 8'h20,
        clus_hi: 16'h0001, clus_lo: 16'h0005, file_len: 32'd1234, default: '0},
      '{cfg_set: 2'd1, named: 1'b1, fill: 8'h20, attr: 8'h10, clus_lo: 16'h0003,
        default: '0},
      '{cfg_set: 2'd1, named: 1'b1, fill: 8'h20, attr: 8'h08, clus_lo: 16'h0004,
        default: '0},
      '{cfg_set: 2'd1, named: 1'b1, fill: 8'h20, own_first: 1'b1, first_byte: DEL_MARK,
        default: '0},
      '{cfg_set: 2'd1, named: 1'b1, fill: 8'h20, own_first: 1'b1, first_byte: END_MARK,
        default: '0},
      '{cfg_set: 2'd1, named: 1'b1, fill: 8'h20, flip_en: 1'b1, flip: 4'd1, default: '0},
      '{cfg_set: 2'd1, named: 1'b1, fill: 8'h20, flip_en: 1'b1, flip: 4'd7, default: '0},
      '{cfg_set: 2'd1, named: 1'b1, fill: 8'h20, flip_en: 1'b1, flip: 4'd8, default: '0},
      '{cfg_set: 2'd1, named: 1'b1, fill: 8'h20, flip_en: 1'b1, flip: 4'd10, default: '0},
      '{cfg_set: 2'd1, named: 1'b1, fill: 8'hA5, cut: 5'd13, clus_lo: 16'h0010,
        file_len: 32'h0001_0000, default: '0},
      '{cfg_set: 2'd1, named: 1'b1, fill: 8'h00, default: '0},
      '{cfg_set: 2'd1, named: 1'b1, fill: 8'h00, clus_lo: 16'h0001, default: '0},
      '{cfg_set: 2'd1, rs: 1'b1, named: 1'b1, fill: 8'hFF, attr: 8'hE7, clus_hi: 16'hFFFF,
        clus_lo: 16'hFFFF, file_len: 32'hFFFF_FFFF, default: '0},
      '{cfg_set: 2'd2, rs: 1'b1, fill: 8'hFF, attr: 8'hFF, clus_hi: 16'hFFFF,
        clus_lo: 16'hFFFF, file_len: 32'hFFFF_FFFF, typed: 1'b1,
        want: '{1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, default: '0},
      '{cfg_set: 2'd2, fill: 8'hFF, attr: 8'hE7, clus_hi: 16'hFFFF,
        clus_lo: 16'hFFFF, file_len: 32'hFFFF_FFFF, typed: 1'b1,
        want: '{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, default: '0}
    };

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cur_set = 0;
    foreach (directed_rows[i]) begin
      if (int'(directed_rows[i].cfg_set) != cur_set) begin
        settle_block();
        cur_set = int'(directed_rows[i].cfg_set);
        load_regs(cur_set);
      end
      send_entry(directed_rows[i]);
    end

    for (p = 0; p < 5; p++) begin
      settle_block();
      plan_random_regs(3);
      load_regs(3);
      for (k = 0; k < 3; k++) begin
        if ($urandom_range(0, 4) == 0) begin
          for (n = $urandom_range(1, 40); n > 0; n--) begin
            send_byte(8'($urandom), $urandom_range(0, 15) == 0);
          end
        end else begin
          send_entry(random_row());
        end
      end
    end

    settle_block();
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ fat_directory_entry_matcher.f @@
sv/fdem_pkg.sv
sv/fdem_req_if.sv
sv/fdem_rsp_if.sv
sv/fdem_apb_regs.sv
sv/fdem_entry_parse.sv
sv/fdem_result.sv
sv/fat_directory_entry_matcher.sv
sv/fdem_checker.sv
sim/tb_fat_directory_entry_matcher.sv
